[rtl/ase_pkg.sv]
package ase_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned ROT_FRAC  = 14;
  localparam int unsigned NUM_AXES  = 3;

  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

  // config register indexes
  localparam logic [2:0] REG_A11 = 3'd0;
  localparam logic [2:0] REG_A12 = 3'd1;
  localparam logic [2:0] REG_A21 = 3'd2;
  localparam logic [2:0] REG_A22 = 3'd3;
  localparam logic [2:0] REG_B1  = 3'd4;
  localparam logic [2:0] REG_B2  = 3'd5;
  localparam logic [2:0] REG_GZ  = 3'd6;

  // sequencer steps
  localparam logic [3:0] ST_MUL_A11  = 4'd0;
  localparam logic [3:0] ST_MUL_A12  = 4'd1;
  localparam logic [3:0] ST_MUL_B1   = 4'd2;
  localparam logic [3:0] ST_MUL_A21  = 4'd3;
  localparam logic [3:0] ST_MUL_A22  = 4'd4;
  localparam logic [3:0] ST_MUL_B2   = 4'd5;
  localparam logic [3:0] ST_ACC_LAST = 4'd6;
  localparam logic [3:0] ST_UPDATE   = 4'd7;
  localparam logic [3:0] ST_GRAV     = 4'd8;
  localparam logic [3:0] ST_ROT0     = 4'd9;
  localparam logic [3:0] ST_ROT1     = 4'd10;
  localparam logic [3:0] ST_ROT2     = 4'd11;
  localparam logic [3:0] ST_ROT_LAST = 4'd12;
  localparam logic [3:0] ST_DONE     = 4'd13;

  typedef struct packed {
    logic signed [31:0] a11;
    logic signed [31:0] a12;
    logic signed [31:0] a21;
    logic signed [31:0] a22;
    logic signed [31:0] b1;
    logic signed [31:0] b2;
  } coef_t;

  typedef struct packed {
    logic       run;
    logic       first;
    logic [3:0] step;
  } ctrl_t;

  typedef struct packed {
    logic signed [47:0] p0;
    logic signed [47:0] p1;
    logic signed [47:0] p2;
  } lane_out_t;

  // round half up by 2^sh, then clamp to 32 bits
  function automatic logic signed [31:0] round_sat(input logic signed [65:0] s,
                                                   input int unsigned sh);
    logic signed [65:0] r;
    r = (s + (66'sd1 <<< (sh - 1))) >>> sh;
    if (r > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (r < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return r[31:0];
  endfunction

endpackage

[rtl/ase_lane.sv]
module ase_lane (
  input  logic                      clk,
  input  logic                      rst,
  input  ase_pkg::ctrl_t            ctrl,
  input  ase_pkg::coef_t            coef,
  input  logic signed [31:0]        grav,
  input  logic signed [31:0]        vel,
  input  logic signed [15:0]        rot_c0,
  input  logic signed [15:0]        rot_c1,
  input  logic signed [15:0]        rot_c2,
  output ase_pkg::lane_out_t        res
);

  logic signed [31:0] xv;
  logic signed [31:0] xa;
  logic signed [31:0] aval;
  logic signed [63:0] prod;
  logic signed [65:0] accv;
  logic signed [65:0] acca;
  logic signed [65:0] prod_ext;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [32:0] gsum;

  assign prod_ext = {{2{prod[63]}}, prod};
  assign gsum     = {xa[31], xa} + {grav[31], grav};

  always_comb begin
    case (ctrl.step)
      ase_pkg::ST_MUL_A11: begin mul_a = coef.a11; mul_b = xv;   end
      ase_pkg::ST_MUL_A12: begin mul_a = coef.a12; mul_b = xa;   end
      ase_pkg::ST_MUL_B1:  begin mul_a = coef.b1;  mul_b = vel;  end
      ase_pkg::ST_MUL_A21: begin mul_a = coef.a21; mul_b = xv;   end
      ase_pkg::ST_MUL_A22: begin mul_a = coef.a22; mul_b = xa;   end
      ase_pkg::ST_MUL_B2:  begin mul_a = coef.b2;  mul_b = vel;  end
      ase_pkg::ST_ROT0:    begin mul_a = {{16{rot_c0[15]}}, rot_c0}; mul_b = aval; end
      ase_pkg::ST_ROT1:    begin mul_a = {{16{rot_c1[15]}}, rot_c1}; mul_b = aval; end
      ase_pkg::ST_ROT2:    begin mul_a = {{16{rot_c2[15]}}, rot_c2}; mul_b = aval; end
      default:             begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      xv <= '0;
      xa <= '0;
    end else if (ctrl.run && ctrl.step == ase_pkg::ST_UPDATE) begin
      if (ctrl.first) begin
        xv <= vel;
        xa <= '0;
      end else begin
        xv <= ase_pkg::round_sat(accv, ase_pkg::FRAC_BITS);
        xa <= ase_pkg::round_sat(acca, ase_pkg::FRAC_BITS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.run) begin
      prod <= mul_a * mul_b;
      case (ctrl.step)
        ase_pkg::ST_MUL_A12:  accv <= prod_ext;
        ase_pkg::ST_MUL_B1,
        ase_pkg::ST_MUL_A21:  accv <= accv + prod_ext;
        ase_pkg::ST_MUL_A22:  acca <= prod_ext;
        ase_pkg::ST_MUL_B2,
        ase_pkg::ST_ACC_LAST: acca <= acca + prod_ext;
        ase_pkg::ST_GRAV: begin
          if (gsum[32] != gsum[31]) begin
            aval <= gsum[32] ? 32'sh80000000 : 32'sh7fffffff;
          end else begin
            aval <= gsum[31:0];
          end
        end
        ase_pkg::ST_ROT1:     res.p0 <= prod[47:0];
        ase_pkg::ST_ROT2:     res.p1 <= prod[47:0];
        ase_pkg::ST_ROT_LAST: res.p2 <= prod[47:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/ase_merge.sv]
module ase_merge (
  input  ase_pkg::lane_out_t  lane0,
  input  ase_pkg::lane_out_t  lane1,
  input  ase_pkg::lane_out_t  lane2,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_z
);

  logic signed [49:0] sx;
  logic signed [49:0] sy;
  logic signed [49:0] sz;

  assign sx = {{2{lane0.p0[47]}}, lane0.p0} + {{2{lane1.p0[47]}}, lane1.p0}
            + {{2{lane2.p0[47]}}, lane2.p0};
  assign sy = {{2{lane0.p1[47]}}, lane0.p1} + {{2{lane1.p1[47]}}, lane1.p1}
            + {{2{lane2.p1[47]}}, lane2.p1};
  assign sz = {{2{lane0.p2[47]}}, lane0.p2} + {{2{lane1.p2[47]}}, lane1.p2}
            + {{2{lane2.p2[47]}}, lane2.p2};

  assign out_x = ase_pkg::round_sat({{16{sx[49]}}, sx}, ase_pkg::ROT_FRAC);
  assign out_y = ase_pkg::round_sat({{16{sy[49]}}, sy}, ase_pkg::ROT_FRAC);
  assign out_z = ase_pkg::round_sat({{16{sz[49]}}, sz}, ase_pkg::ROT_FRAC);

endmodule

[rtl/accel_sensor_kalman_estimator.sv]
// Link-frame acceleration estimator. Each input beat carries the world
// velocity of the sensor point (Q16.16) and the link rotation R (Q2.14);
// each produces one output beat with R^T * (filtered accel + gravity).
// Three axis lanes, each with one 32x32 multiplier, run the two-state filter
// and the rotation products; a merge stage sums across lanes. Each lane's
// multiplier runs the item's nine products in turn. The next item can be
// accepted as soon as the previous one is done, even while its output beat
// still waits. The first item after reset loads the velocity and zeroes the
// acceleration. The user must write config registers through cfg_we/cfg_index/
// cfg_data only while idle; the block itself does not enforce this.
module accel_sensor_kalman_estimator (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] vel_z,
  input  logic signed [15:0] rot_00,
  input  logic signed [15:0] rot_01,
  input  logic signed [15:0] rot_02,
  input  logic signed [15:0] rot_10,
  input  logic signed [15:0] rot_11,
  input  logic signed [15:0] rot_12,
  input  logic signed [15:0] rot_20,
  input  logic signed [15:0] rot_21,
  input  logic signed [15:0] rot_22,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] accel_x,
  output logic signed [31:0] accel_y,
  output logic signed [31:0] accel_z
);

  ase_pkg::coef_t     coef;
  logic signed [31:0] gravity_z;

  logic               busy;
  logic               first;
  logic [3:0]         step;
  ase_pkg::ctrl_t     ctrl;

  logic signed [31:0] vel [ase_pkg::NUM_AXES];
  logic signed [15:0] rot [ase_pkg::NUM_AXES][ase_pkg::NUM_AXES];

  ase_pkg::lane_out_t lane_res [ase_pkg::NUM_AXES];
  logic signed [31:0] mx;
  logic signed [31:0] my;
  logic signed [31:0] mz;

  logic in_fire;
  logic done;

  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;
  assign done     = busy && step == ase_pkg::ST_DONE && (!out_valid || out_ready);

  assign ctrl.run   = busy;
  assign ctrl.first = first;
  assign ctrl.step  = step;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.a11  <= ase_pkg::ONE_Q;
      coef.a12  <= '0;
      coef.a21  <= '0;
      coef.a22  <= ase_pkg::ONE_Q;
      coef.b1   <= '0;
      coef.b2   <= '0;
      gravity_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ase_pkg::REG_A11: coef.a11  <= cfg_data;
        ase_pkg::REG_A12: coef.a12  <= cfg_data;
        ase_pkg::REG_A21: coef.a21  <= cfg_data;
        ase_pkg::REG_A22: coef.a22  <= cfg_data;
        ase_pkg::REG_B1:  coef.b1   <= cfg_data;
        ase_pkg::REG_B2:  coef.b2   <= cfg_data;
        ase_pkg::REG_GZ:  gravity_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      vel[0]    <= vel_x;
      vel[1]    <= vel_y;
      vel[2]    <= vel_z;
      rot[0][0] <= rot_00;
      rot[0][1] <= rot_01;
      rot[0][2] <= rot_02;
      rot[1][0] <= rot_10;
      rot[1][1] <= rot_11;
      rot[1][2] <= rot_12;
      rot[2][0] <= rot_20;
      rot[2][1] <= rot_21;
      rot[2][2] <= rot_22;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      first <= 1'b1;
      step  <= ase_pkg::ST_MUL_A11;
    end else if (in_fire) begin
      busy <= 1'b1;
      step <= ase_pkg::ST_MUL_A11;
    end else if (busy) begin
      if (step == ase_pkg::ST_UPDATE) begin
        first <= 1'b0;
      end
      if (step != ase_pkg::ST_DONE) begin
        step <= step + 4'd1;
      end else if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      accel_x <= mx;
      accel_y <= my;
      accel_z <= mz;
    end
  end

  // lane j holds axis j and row j of R
  ase_lane u_lane0 (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .coef   (coef),
    .grav   (32'sd0),
    .vel    (vel[0]),
    .rot_c0 (rot[0][0]),
    .rot_c1 (rot[0][1]),
    .rot_c2 (rot[0][2]),
    .res    (lane_res[0])
  );

  ase_lane u_lane1 (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .coef   (coef),
    .grav   (32'sd0),
    .vel    (vel[1]),
    .rot_c0 (rot[1][0]),
    .rot_c1 (rot[1][1]),
    .rot_c2 (rot[1][2]),
    .res    (lane_res[1])
  );

  ase_lane u_lane2 (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .coef   (coef),
    .grav   (gravity_z),
    .vel    (vel[2]),
    .rot_c0 (rot[2][0]),
    .rot_c1 (rot[2][1]),
    .rot_c2 (rot[2][2]),
    .res    (lane_res[2])
  );

  ase_merge u_merge (
    .lane0 (lane_res[0]),
    .lane1 (lane_res[1]),
    .lane2 (lane_res[2]),
    .out_x (mx),
    .out_y (my),
    .out_z (mz)
  );

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam logic [2:0] REG_NONE = 3'd7;
  localparam logic [15:0] ROT_P1 = 16'h4000;
  localparam logic [15:0] ROT_M1 = 16'hc000;
  localparam logic [31:0] VEL_MAX = 32'h7fffffff;
  localparam logic [31:0] VEL_MIN = 32'h80000000;
  localparam logic signed [66:0] HALF_Q = 67'sd1 <<< (ase_pkg::FRAC_BITS - 1);
  localparam logic signed [66:0] HALF_R = 67'sd1 <<< (ase_pkg::ROT_FRAC - 1);

  typedef struct packed {
    logic [2:0][31:0] vel;
    logic [8:0][15:0] rot;  // rot[r*3+c]
  } sample_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] accel_x, accel_y, accel_z;
  sample_t cur_beat = '0;

  sample_t beat_q[$];
  logic [2:0][31:0] accel_q[$];
  logic [2:0][31:0] seen_accel, want_accel;
  int n_sent = 0;
  int n_taken = 0;
  int n_mismatch = 0;
  int idle_in_pct = 0;
  int idle_out_pct = 0;
  logic beat_in = 1'b0;
  logic hold_off = 1'b0;
  string axis_name[3] = '{"x", "y", "z"};

  // filter model state and registers
  logic signed [66:0] k_a11, k_a12, k_a21, k_a22, k_b1, k_b2, k_gz;
  logic signed [31:0] est_vel[3];
  logic signed [31:0] est_acc[3];
  logic est_first;

  accel_sensor_kalman_estimator u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .vel_x(cur_beat.vel[0]),
    .vel_y(cur_beat.vel[1]),
    .vel_z(cur_beat.vel[2]),
    .rot_00(cur_beat.rot[0]),
    .rot_01(cur_beat.rot[1]),
    .rot_02(cur_beat.rot[2]),
    .rot_10(cur_beat.rot[3]),
    .rot_11(cur_beat.rot[4]),
    .rot_12(cur_beat.rot[5]),
    .rot_20(cur_beat.rot[6]),
    .rot_21(cur_beat.rot[7]),
    .rot_22(cur_beat.rot[8]),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .accel_x(accel_x),
    .accel_y(accel_y),
    .accel_z(accel_z)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[accel_sensor_kalman_estimator] ERROR");
    $finish;
  end

  function automatic logic signed [31:0] clamp32(input logic signed [66:0] s);
    if (s > 67'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (s < -67'sd2147483648) begin
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  function automatic logic [2:0][31:0] estimate_accel(input sample_t s);
    logic signed [66:0] xv, xa, vin, sum;
    logic signed [66:0] acc[3];
    logic signed [66:0] r0, r1, r2;
    logic [2:0][31:0] res;
    for (int i = 0; i < 3; i++) begin
      vin = $signed(s.vel[i]);
      if (est_first) begin
        est_vel[i] = s.vel[i];
        est_acc[i] = '0;
      end else begin
        xv = est_vel[i];
        xa = est_acc[i];
        est_vel[i] = clamp32((k_a11 * xv + k_a12 * xa + k_b1 * vin + HALF_Q)
                             >>> ase_pkg::FRAC_BITS);
        est_acc[i] = clamp32((k_a21 * xv + k_a22 * xa + k_b2 * vin + HALF_Q)
                             >>> ase_pkg::FRAC_BITS);
      end
    end
    est_first = 1'b0;
    acc[0] = est_acc[0];
    acc[1] = est_acc[1];
    sum = est_acc[2];
    acc[2] = clamp32(sum + k_gz);
    for (int i = 0; i < 3; i++) begin
      r0 = $signed(s.rot[i]);
      r1 = $signed(s.rot[3 + i]);
      r2 = $signed(s.rot[6 + i]);
      res[i] = clamp32((r0 * acc[0] + r1 * acc[1] + r2 * acc[2] + HALF_R)
                       >>> ase_pkg::ROT_FRAC);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    n_mismatch++;
  endtask

  // model update, output check, input prediction
  always @(posedge clk) begin
    beat_in <= in_valid && in_ready;
    if (rst) begin
      k_a11 = ase_pkg::ONE_Q;
      k_a12 = '0;
      k_a21 = '0;
      k_a22 = ase_pkg::ONE_Q;
      k_b1 = '0;
      k_b2 = '0;
      k_gz = '0;
      for (int i = 0; i < 3; i++) begin
        est_vel[i] = '0;
        est_acc[i] = '0;
      end
      est_first = 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ase_pkg::REG_A11: k_a11 = $signed(cfg_data);
          ase_pkg::REG_A12: k_a12 = $signed(cfg_data);
          ase_pkg::REG_A21: k_a21 = $signed(cfg_data);
          ase_pkg::REG_A22: k_a22 = $signed(cfg_data);
          ase_pkg::REG_B1:  k_b1 = $signed(cfg_data);
          ase_pkg::REG_B2:  k_b2 = $signed(cfg_data);
          ase_pkg::REG_GZ:  k_gz = $signed(cfg_data);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        seen_accel[0] = accel_x;
        seen_accel[1] = accel_y;
        seen_accel[2] = accel_z;
        if (accel_q.size() == 0) begin
          report_mismatch("beat with no prediction, accel_x", seen_accel[0], '0);
        end else begin
          want_accel = accel_q.pop_front();
          for (int i = 0; i < 3; i++) begin
            if (seen_accel[i] !== want_accel[i]) begin
              report_mismatch({"accel_", axis_name[i]}, seen_accel[i], want_accel[i]);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        accel_q.push_back(estimate_accel(cur_beat));
        n_taken++;
      end
    end
  end

  // sender
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !beat_in) begin
      in_valid <= 1'b1;
    end else if (beat_q.size() != 0 && $urandom_range(0, 99) >= idle_in_pct) begin
      cur_beat <= beat_q.pop_front();
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver
  always @(negedge clk) begin
    out_ready <= !rst && !hold_off && ($urandom_range(0, 99) >= idle_out_pct);
  end

  // long output stall while the sender keeps offering beats
  initial begin
    wait (n_taken >= 40);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic sample_t make_beat(input logic [31:0] vx, input logic [31:0] vy,
                                        input logic [31:0] vz,
                                        input logic [8:0][15:0] m);
    sample_t b;
    b.vel[0] = vx;
    b.vel[1] = vy;
    b.vel[2] = vz;
    b.rot = m;
    return b;
  endfunction

  function automatic logic [8:0][15:0] rot_diag(input logic [15:0] d);
    logic [8:0][15:0] m;
    m = '0;
    m[0] = d;
    m[4] = d;
    m[8] = d;
    return m;
  endfunction

  function automatic logic [8:0][15:0] signed_perm();
    logic [8:0][15:0] m;
    int c0, c1, c2;
    m = '0;
    c0 = $urandom_range(0, 2);
    c1 = (c0 + 1 + $urandom_range(0, 1)) % 3;
    c2 = 3 - c0 - c1;
    m[c0] = $urandom_range(0, 1) ? ROT_P1 : ROT_M1;
    m[3 + c1] = $urandom_range(0, 1) ? ROT_P1 : ROT_M1;
    m[6 + c2] = $urandom_range(0, 1) ? ROT_P1 : ROT_M1;
    return m;
  endfunction

  function automatic logic [31:0] pick_vel();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 3))
        0: return VEL_MAX;
        1: return VEL_MIN;
        2: return '0;
        default: return 32'hffffffff;
      endcase
    end else if (sel < 5) begin
      return $urandom;
    end
    // within +-20 m/s
    return 32'(int'($urandom_range(0, 2621440)) - 1310720);
  endfunction

  function automatic logic [8:0][15:0] pick_rot();
    logic [8:0][15:0] m;
    if ($urandom_range(0, 9) < 4) begin
      return signed_perm();
    end
    for (int k = 0; k < 9; k++) begin
      case ($urandom_range(0, 9))
        0: m[k] = ROT_P1;
        1: m[k] = ROT_M1;
        2: m[k] = '0;
        default: m[k] = 16'(int'($urandom_range(0, 32768)) - 16384);
      endcase
    end
    return m;
  endfunction

  task automatic push_beat(input sample_t b);
    beat_q.push_back(b);
    n_sent++;
  endtask

  task automatic queue_random(input int n);
    repeat (n) push_beat(make_beat(pick_vel(), pick_vel(), pick_vel(), pick_rot()));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (n_taken != n_sent || accel_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [31:0] moderate_coef();
    return 32'(int'($urandom_range(0, 196608)) - 98304);
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idle_in_pct <= 6;
    idle_out_pct <= 49;

    // typical tracking filter, 10 ms step
    write_reg(ase_pkg::REG_A11, 32'd32768);
    write_reg(ase_pkg::REG_A12, 32'd328);
    write_reg(ase_pkg::REG_A21, -32'sd655360);
    write_reg(ase_pkg::REG_A22, 32'd58982);
    write_reg(ase_pkg::REG_B1, 32'd32768);
    write_reg(ase_pkg::REG_B2, 32'd655360);
    write_reg(ase_pkg::REG_GZ, -32'sd642690);
    push_beat(make_beat(32'h00010000, 32'h00020000, 32'hfffd0000, rot_diag(ROT_P1)));
    push_beat(make_beat(32'h00010000, 32'h00020000, 32'hfffd0000, rot_diag(ROT_P1)));
    push_beat(make_beat(32'h00018000, 32'hffff8000, 32'h00090000, rot_diag(ROT_M1)));
    push_beat(make_beat(VEL_MAX, VEL_MAX, VEL_MAX, {9{ROT_P1}}));
    push_beat(make_beat(VEL_MIN, VEL_MIN, VEL_MIN, {9{ROT_M1}}));
    push_beat(make_beat('0, '0, '0, '0));
    push_beat(make_beat(32'hffffffff, 32'hffffffff, 32'hffffffff, {9{ROT_P1}}));
    push_beat(make_beat(VEL_MAX, VEL_MIN, '0, signed_perm()));
    push_beat(make_beat(32'h00008000, 32'hffff8000, 32'h00000001, rot_diag(ROT_P1)));
    push_beat(make_beat(32'h55555555, 32'haaaaaaaa, 32'h0000ffff,
                        {16'h3fff, 16'h0000, 16'h1fff, 16'he000, 16'h2000,
                         16'hffff, 16'h0001, ROT_M1, ROT_P1}));
    push_beat(make_beat(32'haaaaaaaa, 32'h55555555, 32'hffff0000,
                        {ROT_P1, ROT_M1, 16'h0001, 16'hffff, 16'h2000,
                         16'he000, 16'h1fff, 16'h0000, 16'h3fff}));
    queue_random(150);
    settle();

    // extreme coefficients, saturation everywhere
    write_reg(ase_pkg::REG_A11, VEL_MAX);
    write_reg(ase_pkg::REG_A12, VEL_MIN);
    write_reg(ase_pkg::REG_A21, VEL_MIN);
    write_reg(ase_pkg::REG_A22, VEL_MAX);
    write_reg(ase_pkg::REG_B1, VEL_MAX);
    write_reg(ase_pkg::REG_B2, VEL_MIN);
    write_reg(ase_pkg::REG_GZ, VEL_MIN);
    push_beat(make_beat(VEL_MAX, VEL_MIN, VEL_MAX, {9{ROT_P1}}));
    push_beat(make_beat(VEL_MIN, VEL_MAX, VEL_MIN, {9{ROT_M1}}));
    push_beat(make_beat(VEL_MAX, VEL_MAX, VEL_MAX, rot_diag(ROT_P1)));
    push_beat(make_beat('0, '0, '0, {9{ROT_P1}}));
    queue_random(60);
    settle();

    idle_in_pct <= 49;
    idle_out_pct <= 6;
    // zero dynamics, gravity only; an unmapped index must not land anywhere
    write_reg(ase_pkg::REG_A11, '0);
    write_reg(ase_pkg::REG_A12, '0);
    write_reg(ase_pkg::REG_A21, '0);
    write_reg(ase_pkg::REG_A22, '0);
    write_reg(ase_pkg::REG_B1, '0);
    write_reg(ase_pkg::REG_B2, '0);
    write_reg(ase_pkg::REG_GZ, VEL_MAX);
    write_reg(REG_NONE, 32'h12345678);
    push_beat(make_beat(32'h00010000, 32'h00010000, 32'h00010000, {9{ROT_P1}}));
    push_beat(make_beat(VEL_MIN, VEL_MIN, VEL_MIN, {9{ROT_M1}}));
    queue_random(50);
    settle();

    write_reg(ase_pkg::REG_A11, $urandom);
    write_reg(ase_pkg::REG_A12, $urandom);
    write_reg(ase_pkg::REG_A21, $urandom);
    write_reg(ase_pkg::REG_A22, $urandom);
    write_reg(ase_pkg::REG_B1, $urandom);
    write_reg(ase_pkg::REG_B2, $urandom);
    write_reg(ase_pkg::REG_GZ, $urandom);
    queue_random(100);
    settle();

    idle_in_pct <= 0;
    idle_out_pct <= 0;
    write_reg(ase_pkg::REG_A11, moderate_coef());
    write_reg(ase_pkg::REG_A12, moderate_coef());
    write_reg(ase_pkg::REG_A21, moderate_coef());
    write_reg(ase_pkg::REG_A22, moderate_coef());
    write_reg(ase_pkg::REG_B1, moderate_coef());
    write_reg(ase_pkg::REG_B2, moderate_coef());
    write_reg(ase_pkg::REG_GZ, 32'(int'($urandom_range(0, 12853800)) - 6426900));
    queue_random(170);
    settle();

    repeat (30) @(negedge clk);
    if (n_mismatch == 0 && accel_q.size() == 0) begin
      $display("[accel_sensor_kalman_estimator] OK");
    end else begin
      $display("[accel_sensor_kalman_estimator] ERROR");
    end
    $finish;
  end

endmodule
